// ----- design/exif_pkg.sv -----
// ============================================================================
// exif_pkg
// Shared types, phase codes and signature bytes for the Exif header parser.
// ============================================================================
`default_nettype none

package exif_pkg;

  // one input beat: a byte of the file plus framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } exif_in_t;

  // one result beat
  typedef struct packed {
    logic        header_valid;
    logic        little_endian;
    logic [31:0] ifd_offset;
    logic [15:0] entry_count;
  } exif_out_t;

  // parse phase codes
  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhSoi    = 4'd1;
  localparam logic [3:0] PhApp1   = 4'd2;
  localparam logic [3:0] PhLen    = 4'd3;
  localparam logic [3:0] PhIdent  = 4'd4;
  localparam logic [3:0] PhOrder  = 4'd5;
  localparam logic [3:0] PhFixed  = 4'd6;
  localparam logic [3:0] PhOffset = 4'd7;
  localparam logic [3:0] PhSkip   = 4'd8;
  localparam logic [3:0] PhCount  = 4'd9;
  localparam logic [3:0] PhDone   = 4'd10;

  // signature lengths
  localparam logic [2:0] SoiLen   = 3'd2;
  localparam logic [2:0] App1Len  = 3'd2;
  localparam logic [2:0] IdentLen = 3'd6;

  // byte order marks and fixed code
  localparam logic [7:0] OrderLittle = 8'h49;
  localparam logic [7:0] OrderBig    = 8'h4d;
  localparam logic [7:0] FixedLo     = 8'h2a;
  localparam logic [7:0] FixedHi     = 8'h00;

  // offset of the 0th ifd relative to the tiff header that needs no skip
  localparam logic [31:0] TiffHdrLen = 32'd8;

  function automatic logic [7:0] soi_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'hff;
      3'd1:    b = 8'hd8;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] app1_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'hff;
      3'd1:    b = 8'he1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // "Exif" followed by two zero bytes
  function automatic logic [7:0] ident_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h45;
      3'd1:    b = 8'h78;
      3'd2:    b = 8'h69;
      3'd3:    b = 8'h66;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- design/exif_header_parser.sv -----
// ============================================================================
// exif_header_parser
// Byte-stream parser for the jpeg app1 exif/tiff header: byte order, 0th ifd
// offset and 0th ifd entry count, one result per file.
// ============================================================================
// latency: a result beat shows on out_valid_o the cycle after the byte that
//   ends the parse is accepted, or later if it waits behind a stalled result
// throughput: one byte per cycle, a compare/shift-in step between the parse
//   state and the result register; input stalls only while the skid is full
// reset: asynchronous, active low; parser goes idle and ignores bytes until a
//   beat with first_byte set, output and skid registers are emptied
`default_nettype none

module exif_header_parser (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // byte input channel
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire exif_pkg::exif_in_t in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output exif_pkg::exif_out_t  out_data_o
);
  import exif_pkg::*;

  // parse state
  logic [3:0]  phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] asm_q, asm_d;
  logic        order_q, order_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] saved_q, saved_d;

  // output register plus one skid entry
  logic        out_valid_q, skid_valid_q;
  exif_out_t   out_q, skid_q;

  logic        in_fire, out_fire;
  logic        active, fail, done, res_v;
  logic [7:0]  b;
  exif_out_t   res;

  assign b        = in_data_i.data_byte;
  // a full skid entry is the only thing that holds off new bytes
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // --------------------------------------------------------------------------
  // per-byte parse step
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    asm_d   = asm_q;
    order_d = order_q;
    skip_d  = skip_q;
    saved_d = saved_q;
    fail    = 1'b0;
    done    = 1'b0;

    // a first byte restarts the parse, dropping any unfinished one
    if (in_data_i.first_byte) begin
      phase_d = PhSoi;
      idx_d   = '0;
      asm_d   = '0;
      order_d = 1'b0;
      skip_d  = '0;
      saved_d = '0;
    end

    active = (phase_d != PhIdle) && (phase_d < PhDone);

    unique case (phase_d)
      PhSoi: begin
        if (idx_d >= SoiLen || b != soi_byte(idx_d)) begin
          fail = 1'b1;
        end else if (3'(idx_d + 3'd1) == SoiLen) begin
          idx_d   = '0;
          phase_d = PhApp1;
        end else begin
          idx_d = 3'(idx_d + 3'd1);
        end
      end
      PhApp1: begin
        if (idx_d >= App1Len || b != app1_byte(idx_d)) begin
          fail = 1'b1;
        end else if (3'(idx_d + 3'd1) == App1Len) begin
          idx_d   = '0;
          phase_d = PhLen;
        end else begin
          idx_d = 3'(idx_d + 3'd1);
        end
      end
      PhLen: begin
        // segment length bytes are skipped unchecked
        if (3'(idx_d + 3'd1) >= 3'd2) begin
          idx_d   = '0;
          phase_d = PhIdent;
        end else begin
          idx_d = 3'(idx_d + 3'd1);
        end
      end
      PhIdent: begin
        if (idx_d >= IdentLen || b != ident_byte(idx_d)) begin
          fail = 1'b1;
        end else if (3'(idx_d + 3'd1) == IdentLen) begin
          idx_d   = '0;
          phase_d = PhOrder;
        end else begin
          idx_d = 3'(idx_d + 3'd1);
        end
      end
      PhOrder: begin
        // first mark is parked in the assembly, second must repeat it
        if (idx_d == 3'd0) begin
          if (b != OrderLittle && b != OrderBig) begin
            fail = 1'b1;
          end else begin
            asm_d = {24'd0, b};
            idx_d = 3'd1;
          end
        end else if ({24'd0, b} != asm_d) begin
          fail = 1'b1;
        end else begin
          order_d = (b == OrderLittle);
          asm_d   = '0;
          idx_d   = '0;
          phase_d = PhFixed;
        end
      end
      PhFixed: begin
        // 0x002a in the byte order just read
        if (b != (((idx_d == 3'd0) == order_d) ? FixedLo : FixedHi)) begin
          fail = 1'b1;
        end else if (3'(idx_d + 3'd1) >= 3'd2) begin
          idx_d   = '0;
          phase_d = PhOffset;
        end else begin
          idx_d = 3'(idx_d + 3'd1);
        end
      end
      PhOffset, PhCount: begin
        if (order_d) begin
          unique case (idx_d[1:0])
            2'd0: asm_d[7:0]   = asm_d[7:0]   | b;
            2'd1: asm_d[15:8]  = asm_d[15:8]  | b;
            2'd2: asm_d[23:16] = asm_d[23:16] | b;
            2'd3: asm_d[31:24] = asm_d[31:24] | b;
          endcase
        end else begin
          asm_d = {asm_d[23:0], b};
        end
        idx_d = 3'(idx_d + 3'd1);
        if (phase_d == PhCount) begin
          if (idx_d >= 3'd2) begin
            done = 1'b1;
          end
        end else if (idx_d >= 3'd4) begin
          saved_d = asm_d;
          asm_d   = '0;
          idx_d   = '0;
          // an offset inside the tiff header would be a backward seek
          if (saved_d < TiffHdrLen) begin
            fail = 1'b1;
          end else begin
            skip_d  = saved_d - TiffHdrLen;
            phase_d = (skip_d != '0) ? PhSkip : PhCount;
          end
        end
      end
      PhSkip: begin
        if (skip_d != '0) begin
          skip_d = skip_d - 32'd1;
        end
        if (skip_d == '0) begin
          phase_d = PhCount;
        end
      end
      default: begin
        // idle or finished: byte ignored
      end
    endcase

    res_v = active && (done || fail || in_data_i.end_of_file);
    if (res_v) begin
      phase_d = PhDone;
    end

    res.header_valid  = done;
    res.little_endian = order_d;
    res.ifd_offset    = saved_d;
    res.entry_count   = done ? asm_d[15:0] : 16'd0;
  end

  // --------------------------------------------------------------------------
  // parse state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      idx_q   <= '0;
      asm_q   <= '0;
      order_q <= 1'b0;
      skip_q  <= '0;
      saved_q <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      asm_q   <= asm_d;
      order_q <= order_d;
      skip_q  <= skip_d;
      saved_q <= saved_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register with skid entry
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // no byte is taken while the skid entry is full
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_v) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_v) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // a result closes the parse until the next file
  a_result_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_v) |=> (phase_q == PhDone))
    else $error("parse not closed after result");

  // a valid header never carries a backward offset
  a_valid_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.header_valid) |-> (out_data_o.ifd_offset >= TiffHdrLen))
    else $error("valid header with offset below tiff header length");

  // entry count only reported with a complete header
  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.header_valid) |-> (out_data_o.entry_count == 16'd0))
    else $error("entry count nonzero on failed header");

endmodule

`default_nettype wire
